FILE: hw/rtl/itad_pkg.sv
package itad_pkg;

    typedef enum logic [1:0] {
        FMT_SDEC = 2'd0,
        FMT_UDEC = 2'd1,
        FMT_LHEX = 2'd2,
        FMT_UHEX = 2'd3
    } t_fmt;

    typedef struct packed {
        logic is_dec;
        logic upper;
    } t_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_back_state;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [3:0] DIGIT_TEN    = 4'd10;
    localparam logic [3:0] BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD  = 4'd3;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + {4'd0, d};
        end
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + {4'd0, d} - {4'd0, DIGIT_TEN};
    endfunction

endpackage

FILE: hw/rtl/integer_to_ascii_digits.sv
// Channel   Dir  tdata (low bit up)                 tuser      tlast
// s_axis    in   value [VALUE_WIDTH-1:0], zero pad  format     -
// m_axis    out  character [7:0]                    -          last digit
//
// Decimal: the back end takes the item from the queue, runs 4-bit-per-cycle double
// dabble, then emits the digits most significant first (10 digits max at 32 bits).
// Hex: the back end takes the item, then emits the digits. Pop, conversion and
// emission run in series in the back end, which sets the rate.
// A 2-entry queue decouples the input side; stalls on m_axis hold the output register.
// Reset is synchronous, active low, and empties the queue and the output register.
module integer_to_ascii_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,  // value, pad
    input  logic [1:0]                            i_s_axis_tuser,  // format
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [7:0]                            o_m_axis_tdata,  // character
    output logic                                  o_m_axis_tlast
);

    localparam int DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int ENTRY_W = VALUE_WIDTH + $bits(itad_pkg::t_flags);

    logic               push;
    logic               q_full;
    logic [ENTRY_W-1:0] entry;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;

    itad_front #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .DATA_W     (DATA_W)
    ) u_front (
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_entry        (entry)
    );

    itad_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (entry),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    itad_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

endmodule

FILE: hw/rtl/itad_front.sv
module itad_front #(
    parameter int VALUE_WIDTH = 32,
    parameter int DATA_W      = 32
) (
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  logic [DATA_W-1:0]                          i_s_axis_tdata,
    input  logic [1:0]                                 i_s_axis_tuser,
    input  logic                                       i_q_full,
    output logic                                       o_push,
    output logic [VALUE_WIDTH+$bits(itad_pkg::t_flags)-1:0] o_entry
);

    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] mag;
    itad_pkg::t_fmt         fmt;
    itad_pkg::t_flags       flags;

    assign value = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign fmt   = itad_pkg::t_fmt'(i_s_axis_tuser);

    always_comb begin
        mag = value;
        // signed decimal prints the magnitude; most negative value wraps to itself
        if (fmt == itad_pkg::FMT_SDEC && value[VALUE_WIDTH-1]) begin
            mag = ~value + VALUE_WIDTH'(1);
        end
        flags.is_dec = (fmt == itad_pkg::FMT_SDEC) || (fmt == itad_pkg::FMT_UDEC);
        flags.upper  = (fmt == itad_pkg::FMT_UHEX);
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;
    assign o_entry         = {flags, mag};

endmodule

FILE: hw/rtl/itad_queue.sv
module itad_queue #(
    parameter int WIDTH = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/itad_back.sv
module itad_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_valid,
    input  logic [VALUE_WIDTH+$bits(itad_pkg::t_flags)-1:0] i_q_data,
    output logic                                       o_q_pop,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    output logic [7:0]                                 o_m_axis_tdata,
    output logic                                       o_m_axis_tlast
);

    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int STEPS = (VALUE_WIDTH + 3) / 4;
    localparam int PADW  = STEPS * 4;
    localparam int BW    = NDIG * 4;
    localparam int IDXW  = $clog2(NDIG);
    localparam int CNTW  = $clog2(STEPS + 1);

    itad_pkg::t_flags       q_flags;
    logic [VALUE_WIDTH-1:0] q_mag;

    itad_pkg::t_back_state r_state, n_state;
    logic [PADW-1:0]       r_bits, n_bits;
    logic [BW-1:0]         r_bcd, n_bcd;
    logic [CNTW-1:0]       r_cnt, n_cnt;
    logic [IDXW-1:0]       r_idx, n_idx;
    logic                  r_first, n_first;
    logic                  r_upper, n_upper;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [BW-1:0]   dd_next;
    logic [IDXW-1:0] lead;
    logic [IDXW-1:0] idx_cur;
    logic [3:0]      digit_cur;
    logic            out_free;

    assign {q_flags, q_mag} = i_q_data;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // four double-dabble steps per cycle: adjust each BCD digit, then shift one bit in
    always_comb begin
        logic [BW-1:0] tmp;
        tmp = r_bcd;
        for (int b = 0; b < 4; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (tmp[d*4 +: 4] >= itad_pkg::BCD_ADJ_MIN) begin
                    tmp[d*4 +: 4] = tmp[d*4 +: 4] + itad_pkg::BCD_ADJ_ADD;
                end
            end
            tmp = {tmp[BW-2:0], r_bits[PADW-1-b]};
        end
        dd_next = tmp;
    end

    // highest nonzero digit; zero value leaves digit 0
    always_comb begin
        lead = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                lead = IDXW'(i);
            end
        end
    end

    assign idx_cur   = r_first ? lead : r_idx;
    assign digit_cur = r_bcd[idx_cur*4 +: 4];

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_first     = r_first;
        n_upper     = r_upper;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            itad_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_upper = q_flags.upper;
                    if (q_flags.is_dec) begin
                        n_bits  = PADW'(q_mag);
                        n_bcd   = '0;
                        n_cnt   = CNTW'(STEPS);
                        n_state = itad_pkg::ST_CONV;
                    end else begin
                        // hex digits are the nibbles themselves
                        n_bcd   = BW'(q_mag);
                        n_first = 1'b1;
                        n_state = itad_pkg::ST_EMIT;
                    end
                end
            end
            itad_pkg::ST_CONV: begin
                n_bits = r_bits << 4;
                n_bcd  = dd_next;
                n_cnt  = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_first = 1'b1;
                    n_state = itad_pkg::ST_EMIT;
                end
            end
            itad_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itad_pkg::digit_char(digit_cur, r_upper);
                    n_out_last  = (idx_cur == '0);
                    n_idx       = idx_cur - IDXW'(1);
                    n_first     = 1'b0;
                    if (idx_cur == '0) begin
                        n_state = itad_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = itad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itad_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_first    <= n_first;
        r_upper    <= n_upper;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: hw/rtl/itad_checker.sv
module itad_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // high while the next item on m_axis opens a new number
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_first <= o_m_axis_tlast;
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("m_axis tvalid dropped under stall");

    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("m_axis item changed under stall");

    a_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata >= 8'h30 && o_m_axis_tdata <= 8'h39) ||
            (o_m_axis_tdata >= 8'h61 && o_m_axis_tdata <= 8'h66) ||
            (o_m_axis_tdata >= 8'h41 && o_m_axis_tdata <= 8'h46))
        else $error("m_axis character is not a digit");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_first && o_m_axis_tdata == 8'h30 |-> o_m_axis_tlast)
        else $error("leading zero emitted");

endmodule

bind integer_to_ascii_digits itad_checker u_itad_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tlast (o_m_axis_tlast)
);

FILE: test/integer_to_ascii_digits_tb.sv
module integer_to_ascii_digits_tb;

    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned LONG_HOLD_AT = 300;
    localparam int unsigned RANDOM_ITEMS = 430;
    localparam int unsigned END_SETTLE   = 40;
    localparam logic [7:0]  ASCII_ZERO    = "0";
    localparam logic [7:0]  ASCII_LOWER_A = "a";
    localparam logic [7:0]  ASCII_UPPER_A = "A";

    typedef struct {
        logic [31:0]    value;
        itad_pkg::t_fmt fmt;
        int unsigned    gap;
        bit             drain_first;
    } t_number_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_digit_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;    // value
    logic [1:0]  i_s_axis_tuser = '0;    // format
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // character
    logic        o_m_axis_tlast;

    t_number_item number_q[$];
    t_digit_exp   pending_digits[$];
    int unsigned  n_total;
    int unsigned  n_sent = 0;
    int unsigned  n_digits = 0;
    int unsigned  n_errors = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  gap_left = 0;
    int unsigned  stall_left = 0;

    wire in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    wire out_fire = o_m_axis_tvalid && i_m_axis_tready;

    integer_to_ascii_digits #(
        .VALUE_WIDTH(32)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Expected digits of one number, most significant first.
    function automatic void predict_digits(input logic [31:0] raw,
                                           input itad_pkg::t_fmt fmt);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  d;
        logic [7:0]  rev [12];
        int          n;
        t_digit_exp  e;
        mag = raw;
        // signed format prints the magnitude; the most negative value wraps to itself
        if (fmt == itad_pkg::FMT_SDEC && raw[31]) mag = ~raw + 32'd1;
        radix = (fmt == itad_pkg::FMT_SDEC || fmt == itad_pkg::FMT_UDEC) ? 32'd10 : 32'd16;
        n = 0;
        do begin
            d = 4'(mag % radix);
            if (d < 4'd10) rev[n] = ASCII_ZERO + 8'(d);
            else rev[n] = ((fmt == itad_pkg::FMT_UHEX) ? ASCII_UPPER_A : ASCII_LOWER_A)
                          + 8'(d) - 8'd10;
            mag = mag / radix;
            n++;
        end while (mag != 0);
        for (int k = n - 1; k >= 0; k--) begin
            e.ch   = rev[k];
            e.last = (k == 0);
            pending_digits.push_back(e);
        end
    endfunction

    function automatic void add_number(input logic [31:0] value, input itad_pkg::t_fmt fmt,
                                       input int unsigned gap, input bit drain_first);
        t_number_item it;
        it.value       = value;
        it.fmt         = fmt;
        it.gap         = gap;
        it.drain_first = drain_first;
        number_q.push_back(it);
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] p;
        int unsigned k;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 20);
            2: begin
                // around decimal digit-count boundaries
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            3: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            4: return -$urandom_range(1, 1000);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    initial begin
        int unsigned g;
        for (int f = 0; f < 4; f++)
            add_number(32'd0, itad_pkg::t_fmt'(f), $urandom_range(0, 10), 1'b0);
        for (int f = 0; f < 4; f++)
            add_number(32'hFFFF_FFFF, itad_pkg::t_fmt'(f), $urandom_range(0, 10), 1'b0);
        add_number(32'h8000_0000, itad_pkg::FMT_SDEC, 0, 1'b0);
        add_number(32'h8000_0000, itad_pkg::FMT_UDEC, 0, 1'b0);
        add_number(32'h8000_0000, itad_pkg::FMT_LHEX, 0, 1'b0);
        add_number(32'h7FFF_FFFF, itad_pkg::FMT_SDEC, 3, 1'b0);
        add_number(32'd1, itad_pkg::FMT_SDEC, 0, 1'b0);
        add_number(32'd9, itad_pkg::FMT_UDEC, 1, 1'b0);
        add_number(32'd10, itad_pkg::FMT_UDEC, 0, 1'b0);
        add_number(32'd15, itad_pkg::FMT_LHEX, 0, 1'b0);
        add_number(32'd16, itad_pkg::FMT_UHEX, 2, 1'b0);
        add_number(32'hABCD_EF01, itad_pkg::FMT_LHEX, 0, 1'b0);
        add_number(32'hABCD_EF01, itad_pkg::FMT_UHEX, 0, 1'b0);
        add_number(32'd1_000_000_000, itad_pkg::FMT_UDEC, 0, 1'b0);
        add_number(32'd999_999_999, itad_pkg::FMT_SDEC, 5, 1'b0);
        add_number(32'h5A5A_5A5A, itad_pkg::FMT_UDEC, 0, 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // a stretch with no sender gaps backs up against the long receiver hold
            g = (i >= 20 && i < 100) ? 0 : $urandom_range(0, 10);
            add_number(random_value(), itad_pkg::t_fmt'($urandom_range(0, 3)), g,
                       (i == 0 || i == 300));
        end
        n_total = number_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total) @(posedge i_clk);
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        t_number_item cur;
        int unsigned  gap_now;
        gap_now = gap_left;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left        <= 0;
        end else begin
            if (in_fire) begin
                predict_digits(i_s_axis_tdata, itad_pkg::t_fmt'(i_s_axis_tuser));
                n_sent++;
                gap_now = (number_q.size() != 0) ? number_q[0].gap : 0;
            end
            if (i_s_axis_tvalid && !in_fire) begin
                // hold the offered item
            end else if (gap_now != 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left        <= gap_now - 1;
            end else if (number_q.size() != 0 &&
                         !(number_q[0].drain_first && pending_digits.size() != 0)) begin
                cur = number_q.pop_front();
                i_s_axis_tdata  <= cur.value;
                i_s_axis_tuser  <= cur.fmt;
                i_s_axis_tvalid <= 1'b1;
                gap_left        <= 0;
            end else begin
                i_s_axis_tvalid <= 1'b0;
                gap_left        <= 0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_digit_exp  e;
        int unsigned s;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= 0;
        end else if (out_fire) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit: char %h last %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                n_errors++;
            end else begin
                e = pending_digits.pop_front();
                if (o_m_axis_tdata !== e.ch) begin
                    $display("%0t: char mismatch: expected %h, got %h",
                             $time, e.ch, o_m_axis_tdata);
                    n_errors++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, e.last, o_m_axis_tlast);
                    n_errors++;
                end
            end
            n_digits++;
            if (n_digits == LONG_HOLD_AT) s = LONG_HOLD;
            else if ((n_digits / 256) % 4 == 3) s = 0;
            else s = $urandom_range(0, 10);
            if (s == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                stall_left      <= s;
            end
        end else if (!i_m_axis_tready) begin
            if (stall_left <= 1) begin
                i_m_axis_tready <= 1'b1;
                stall_left      <= 0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
